// ===== hw/rtl/uer_pkg.sv =====
// Package for the ultrasonic echo ranger: request/response payloads, phase
// encoding, register indexes and distance scaling constants.
// No dependencies.
`timescale 1ns / 1ps

package uer_pkg;

   // Request payload: one tick
   typedef struct packed {
      logic [31:0] now_ms;
      logic [9:0]  echo_sample;
   } req_type;

   // Response payload: one result per tick
   typedef struct packed {
      logic        trigger_level;
      logic        reading_valid;
      logic [15:0] distance;
   } rsp_type;

   // Middle pipeline stage: control outcome of a tick, before scaling
   typedef struct packed {
      logic        trigger_level;
      logic        reading_valid;
      logic        saturate;
      logic [13:0] elapsed;
   } mid_type;

   // Ranging cycle phases, one-hot
   typedef enum logic [4:0] {
      PH_IDLE      = 5'b00001,
      PH_TRIGGER   = 5'b00010,
      PH_WAIT_RISE = 5'b00100,
      PH_WAIT_FALL = 5'b01000,
      PH_SETTLE    = 5'b10000
   } phase_type;

   // Register indexes
   typedef enum logic [1:0] {
      CSR_ECHO_THRESHOLD = 2'd0,
      CSR_TRIGGER_TIME   = 2'd1,
      CSR_SETTLE_TIME    = 2'd2
   } csr_index_type;

   // Register reset values
   localparam logic [9:0]  ECHO_THRESHOLD_RST = 10'd0;
   localparam logic [15:0] TRIGGER_TIME_RST   = 16'd11;
   localparam logic [15:0] SETTLE_TIME_RST    = 16'd21;

   // distance = floor(elapsed * 1000 / 148) = floor(elapsed * 250 / 37).
   // Any elapsed of 9700 ms or more gives a value above 65535.
   localparam logic [31:0] SAT_ELAPSED = 32'd9700;
   // 250 * ceil(2^27 / 37); exact for every elapsed below SAT_ELAPSED
   localparam logic [29:0] DIST_RECIP  = 30'd906876750;
   localparam int          DIST_SHIFT  = 27;
   localparam logic [15:0] DIST_MAX    = 16'hFFFF;

endpackage

// ===== hw/rtl/uer_dist_scale.sv =====
// Distance scaler: turns a registered echo duration into the response payload.
// Depends on uer_pkg.
`timescale 1ns / 1ps

module uer_dist_scale
   import uer_pkg::*;
(
   input  mid_type mid_data,
   output rsp_type rsp_out
);

   logic [43:0] product;
   logic [15:0] quotient;

   // Divide by 37 through a reciprocal multiply, then saturate
   assign product  = {30'd0, mid_data.elapsed} * {14'd0, DIST_RECIP};
   assign quotient = product[DIST_SHIFT +: 16];

   always_comb begin
      rsp_out.trigger_level = mid_data.trigger_level;
      rsp_out.reading_valid = mid_data.reading_valid;
      if (!mid_data.reading_valid) begin
         rsp_out.distance = 16'd0;
      end else if (mid_data.saturate) begin
         rsp_out.distance = DIST_MAX;
      end else begin
         rsp_out.distance = quotient;
      end
   end

endmodule

// ===== hw/rtl/ultrasonic_echo_ranger_top.sv =====
// Ultrasonic echo ranger: per-tick phase sequencer, registers and pipeline.
// Depends on uer_pkg and uer_dist_scale.
`timescale 1ns / 1ps

// The block takes one tick request per cycle unless the pipeline is stalled
// and returns exactly one response per tick. The tick passes three registers:
// the input register, the phase/elapsed register and the response register,
// which drives the response valid and data. The
// phase sequencer and its mark time update in the cycle a tick leaves the
// input register, so consecutive ticks see each other's effect without
// bubbles; the distance multiply sits in its own stage after that. Stalls on
// the response side back up one stage at a time, so a request can still be
// taken while a finished response waits. Write registers only when no tick
// is in flight.
module ultrasonic_echo_ranger_top
   import uer_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   // Configuration registers
   logic [9:0]  threshold_ff;
   logic [15:0] trig_time_ff;
   logic [15:0] settle_time_ff;

   // Pipeline registers
   logic      s1_valid_ff, s1_valid_in;
   req_type   s1_data_ff;
   logic      mid_valid_ff, mid_valid_in;
   mid_type   mid_data_ff, mid_data_in;
   logic      out_valid_ff, out_valid_in;
   rsp_type   out_data_ff;
   rsp_type   scaled;

   // Sequencer state
   phase_type   phase_ff, phase_in;
   logic [31:0] mark_ff, mark_in;
   logic        trig_ff, trig_in;

   logic        out_en, mid_en, s1_en, step;
   logic [31:0] elapsed;
   logic        echo_high;
   logic        reading;

   // Write configuration registers; drop writes beyond the list
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff   <= ECHO_THRESHOLD_RST;
         trig_time_ff   <= TRIGGER_TIME_RST;
         settle_time_ff <= SETTLE_TIME_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_ECHO_THRESHOLD: threshold_ff   <= csr_wdata[9:0];
            CSR_TRIGGER_TIME:   trig_time_ff   <= csr_wdata;
            CSR_SETTLE_TIME:    settle_time_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Stage enables: each stage advances when empty or when the next one moves
   assign out_en    = !out_valid_ff || rsp_ready;
   assign mid_en    = !mid_valid_ff || out_en;
   assign s1_en     = !s1_valid_ff || mid_en;
   assign req_ready = s1_en;
   assign step      = s1_valid_ff && mid_en;

   assign s1_valid_in  = s1_en ? req_valid : s1_valid_ff;
   assign mid_valid_in = mid_en ? s1_valid_ff : mid_valid_ff;
   assign out_valid_in = out_en ? mid_valid_ff : out_valid_ff;

   // Tick decode against current sequencer state
   assign elapsed   = s1_data_ff.now_ms - mark_ff;
   assign echo_high = s1_data_ff.echo_sample > threshold_ff;

   // Advance the ranging cycle by one tick
   always_comb begin
      phase_in = phase_ff;
      mark_in  = mark_ff;
      trig_in  = trig_ff;
      reading  = 1'b0;
      case (phase_ff)
         PH_IDLE: begin
            mark_in  = s1_data_ff.now_ms;
            phase_in = PH_TRIGGER;
         end
         PH_TRIGGER: begin
            trig_in = 1'b1;
            if (elapsed >= {16'd0, trig_time_ff}) begin
               phase_in = PH_WAIT_RISE;
            end
         end
         PH_WAIT_RISE: begin
            trig_in = 1'b0;
            if (echo_high) begin
               mark_in  = s1_data_ff.now_ms;
               phase_in = PH_WAIT_FALL;
            end
         end
         PH_WAIT_FALL: begin
            if (!echo_high) begin
               reading  = 1'b1;
               mark_in  = s1_data_ff.now_ms;
               phase_in = PH_SETTLE;
            end
         end
         PH_SETTLE: begin
            if (elapsed >= {16'd0, settle_time_ff}) begin
               phase_in = PH_IDLE;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   // Hand the tick outcome to the scaling stage
   always_comb begin
      mid_data_in.trigger_level = trig_in;
      mid_data_in.reading_valid = reading;
      mid_data_in.saturate      = elapsed >= SAT_ELAPSED;
      mid_data_in.elapsed       = elapsed[13:0];
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         mid_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         phase_ff     <= PH_IDLE;
         mark_ff      <= 32'd0;
         trig_ff      <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         mid_valid_ff <= mid_valid_in;
         out_valid_ff <= out_valid_in;
         if (step) begin
            phase_ff <= phase_in;
            mark_ff  <= mark_in;
            trig_ff  <= trig_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (s1_en && req_valid) begin
         s1_data_ff <= req_data;
      end
      if (step) begin
         mid_data_ff <= mid_data_in;
      end
      if (out_en && mid_valid_ff) begin
         out_data_ff <= scaled;
      end
   end

   uer_dist_scale u_dist_scale (
      .mid_data (mid_data_ff),
      .rsp_out  (scaled)
   );

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // A response without a reading carries no distance
   a_no_stray_distance: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.reading_valid) |-> (rsp_data.distance == 16'd0))
      else $error("distance set without a reading");

   // Trigger is only driven while triggering or just after
   a_trigger_phase: assert property (@(posedge clock) disable iff (reset)
      trig_ff |-> (phase_ff == PH_TRIGGER || phase_ff == PH_WAIT_RISE))
      else $error("trigger high outside trigger phase");

   // A completed reading moves to settle and marks the fall time
   a_reading_to_settle: assert property (@(posedge clock) disable iff (reset)
      (step && reading) |=> (phase_ff == PH_SETTLE &&
                             mark_ff == $past(s1_data_ff.now_ms)))
      else $error("reading did not enter settle");

   // Backpressure only when the input register is occupied
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> s1_valid_ff)
      else $error("request refused with empty input stage");

   // Sequencer state holds while no tick advances
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !step |=> ($stable(phase_ff) && $stable(mark_ff) && $stable(trig_ff)))
      else $error("sequencer state moved without a tick");

endmodule
